>>> rtl/sector_range_lock_table_macros.svh
// Assertion macros for the sector range lock table.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef SECTOR_RANGE_LOCK_TABLE_MACROS_SVH
`define SECTOR_RANGE_LOCK_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define SRLT_ASSERT(lbl, clock, reset, prop) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("sector range lock table assertion failed");

// The condition must never be true outside reset.
`define SRLT_ASSERT_NEVER(lbl, clock, reset, cond) \
  lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
    else $error("sector range lock table forbidden condition seen");

`else

`define SRLT_ASSERT(lbl, clock, reset, prop)
`define SRLT_ASSERT_NEVER(lbl, clock, reset, cond)

`endif

`endif

>>> rtl/srlt_pkg.sv
// Shared types and constants of the sector range lock table.
// No dependencies; used by srlt_ctrl and sector_range_lock_table.
package srlt_pkg;

  localparam int TABLE_CAPACITY = 1024;
  localparam int SECTOR_W       = 64;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CHECK = 1'b1
  } cmd_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [SECTOR_W-1:0] range_begin;
    logic [SECTOR_W-1:0] range_end;
    logic [SECTOR_W-1:0] sector;
  } item_t;

  typedef struct packed {
    logic                valid;
    logic [SECTOR_W-1:0] locked_remaining;
    status_t             status;
  } result_t;

endpackage

>>> rtl/srlt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module srlt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/srlt_ctrl.sv
// Scan controller: walks the filled entries through the table RAM, widens or
// appends ranges and forms one result per item. Depends on srlt_pkg and the
// assertion macros header.
`include "sector_range_lock_table_macros.svh"

module srlt_ctrl #(
  parameter int TABLE_CAPACITY = srlt_pkg::TABLE_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  srlt_pkg::item_t                     item,
  output srlt_pkg::result_t                   res,
  input  logic                                res_ready,
  output logic                                ram_wr_en,
  output logic [$clog2(TABLE_CAPACITY)-1:0]   ram_wr_addr,
  output logic [2*srlt_pkg::SECTOR_W-1:0]     ram_wr_data,
  output logic                                ram_rd_en,
  output logic [$clog2(TABLE_CAPACITY)-1:0]   ram_rd_addr,
  input  logic [2*srlt_pkg::SECTOR_W-1:0]     ram_rd_data
);

  localparam int AW = $clog2(TABLE_CAPACITY);
  localparam int CW = $clog2(TABLE_CAPACITY + 1);
  localparam int SW = srlt_pkg::SECTOR_W;
  localparam logic [CW-1:0] CAP_C = CW'(TABLE_CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t               state;
  srlt_pkg::item_t      cur;
  logic [CW-1:0]        count;
  logic [CW-1:0]        rd_ptr;
  logic                 cmp_valid;
  logic [AW-1:0]        cmp_idx;
  logic [SW-1:0]        res_remaining;
  srlt_pkg::status_t    res_status;

  logic [SW-1:0] eb;
  logic [SW-1:0] ee;
  logic [SW-1:0] nb;
  logic [SW-1:0] ne;
  logic          rd_more;
  logic          add_hit;
  logic          chk_hit;
  logic          hit;
  logic          scan_end;
  logic          is_add;
  logic          has_room;
  logic          finish;

  always_comb begin
    eb       = ram_rd_data[SW-1:0];
    ee       = ram_rd_data[2*SW-1:SW];
    is_add   = (cur.cmd == srlt_pkg::CMD_ADD);
    rd_more  = (rd_ptr < count);
    has_room = (count < CAP_C);
    add_hit  = (eb < cur.range_end) && (cur.range_begin < ee);
    chk_hit  = (cur.sector >= eb) && (cur.sector < ee);
    hit      = cmp_valid && (is_add ? add_hit : chk_hit);
    // The scan is over without a hit once no read is in flight or left.
    scan_end = !cmp_valid && !rd_more;
    finish   = (state == ST_SCAN) && (hit || scan_end);
    nb       = (cur.range_begin < eb) ? cur.range_begin : eb;
    ne       = (cur.range_end > ee) ? cur.range_end : ee;

    ram_rd_en   = (state == ST_SCAN) && rd_more;
    ram_rd_addr = rd_ptr[AW-1:0];
    ram_wr_en   = (state == ST_SCAN) && is_add && (hit || (scan_end && has_room));
    ram_wr_addr = hit ? cmp_idx : count[AW-1:0];
    ram_wr_data = hit ? {ne, nb} : {cur.range_end, cur.range_begin};

    item_ready           = (state == ST_IDLE);
    res.valid            = (state == ST_DONE);
    res.locked_remaining = res_remaining;
    res.status           = res_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_ptr    <= '0;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur       <= item;
            rd_ptr    <= '0;
            cmp_valid <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_more) begin
            rd_ptr <= rd_ptr + CW'(1);
          end
          cmp_valid <= rd_more;
          cmp_idx   <= rd_ptr[AW-1:0];
          if (finish) begin
            state         <= ST_DONE;
            res_remaining <= (hit && !is_add) ? (ee - cur.sector) : '0;
            res_status    <= (is_add && !hit && !has_room) ?
                             srlt_pkg::STATUS_FULL : srlt_pkg::STATUS_OK;
            if (is_add && !hit && has_room) begin
              count <= count + CW'(1);
            end
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SRLT_ASSERT_NEVER(a_count_in_range, clk, rst, count > CAP_C)
  `SRLT_ASSERT(a_count_steps_by_one, clk, rst,
    (!$past(rst) && count != $past(count)) |-> (count == $past(count) + CW'(1)))
  `SRLT_ASSERT(a_write_inside_fill, clk, rst,
    ram_wr_en |-> ({1'b0, ram_wr_addr} <= {1'b0, count}))
  `SRLT_ASSERT(a_full_only_at_capacity, clk, rst,
    (res.valid && res.status == srlt_pkg::STATUS_FULL) |-> (count == CAP_C))

endmodule

>>> rtl/sector_range_lock_table.sv
// Top level of the sector range lock table: stream ports, output register,
// table RAM and scan controller. Depends on srlt_pkg, srlt_ram, srlt_ctrl.
//
// The block keeps up to TABLE_CAPACITY half-open sector ranges [begin,end) in
// one RAM of begin/end pairs and answers one result item per input item. An
// add item (tuser 0) widens the first stored range that overlaps it, or else
// appends it; with the table full and no overlap the range is dropped and
// status (m_tuser) reads 1. A check item (tuser 1) returns end minus sector
// for the first stored range holding the sector, or 0. Each item is handled
// by a linear scan that reads one entry per cycle from the RAM's single read
// port and stops at the first hit or once every filled entry has been read.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is taken. Reset needs no clearing pass.
module sector_range_lock_table #(
  parameter int TABLE_CAPACITY = srlt_pkg::TABLE_CAPACITY
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // range_begin[63:0], range_end[127:64], sector[191:128]
  input  logic [0:0]   s_tuser,   // cmd[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // locked_remaining[63:0]
  output logic [0:0]   m_tuser    // status[0]
);

  localparam int AW = $clog2(TABLE_CAPACITY);
  localparam int SW = srlt_pkg::SECTOR_W;

  srlt_pkg::item_t   item;
  srlt_pkg::result_t res;
  logic              res_ready;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [2*SW-1:0]   ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [2*SW-1:0]   ram_rd_data;

  always_comb begin
    item.cmd         = srlt_pkg::cmd_t'(s_tuser[0]);
    item.range_begin = s_tdata[SW-1:0];
    item.range_end   = s_tdata[2*SW-1:SW];
    item.sector      = s_tdata[3*SW-1:2*SW];
    res_ready        = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res.valid;
    end
    if (res_ready && res.valid) begin
      m_tdata    <= res.locked_remaining;
      m_tuser[0] <= res.status;
    end
  end

  srlt_ram #(
    .WIDTH (2 * SW),
    .DEPTH (TABLE_CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  srlt_ctrl #(
    .TABLE_CAPACITY (TABLE_CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (s_tvalid),
    .item_ready  (s_tready),
    .item        (item),
    .res         (res),
    .res_ready   (res_ready),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for sector_range_lock_table: drives add and check items on the
// input stream, predicts every answer from a private copy of the lock table, compares results.
// Depends on srlt_pkg and the sector_range_lock_table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int            CYCLE_LIMIT     = 6_000_000;
  localparam int            PRESSURE_CYCLES = 4000;
  localparam int            RANDOM_ITEMS    = 540;
  localparam logic [63:0]   SECTOR_MAX      = '1;

  // Mirror of the lock table and the answers still owed by the block.
  class lock_tracker;
    typedef struct {
      logic [63:0]        remaining;
      srlt_pkg::status_t  status;
    } answer_t;

    logic [63:0] lock_lo [srlt_pkg::TABLE_CAPACITY];
    logic [63:0] lock_hi [srlt_pkg::TABLE_CAPACITY];
    int          fill;
    int          errors;
    answer_t     owed [$];

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Index of the first stored range that strictly overlaps [b,e), or -1.
    function int first_overlap(logic [63:0] b, logic [63:0] e);
      for (int k = 0; k < fill; k++) begin
        if (lock_lo[k] < e && b < lock_hi[k]) return k;
      end
      return -1;
    endfunction

    function void note_request(srlt_pkg::item_t it);
      answer_t ans;
      int      k;
      bit      found;
      ans.remaining = '0;
      ans.status    = srlt_pkg::STATUS_OK;
      found         = 1'b0;
      if (it.cmd == srlt_pkg::CMD_ADD) begin
        k = first_overlap(it.range_begin, it.range_end);
        if (k >= 0) begin
          if (it.range_begin < lock_lo[k]) lock_lo[k] = it.range_begin;
          if (it.range_end > lock_hi[k]) lock_hi[k] = it.range_end;
        end else if (fill == srlt_pkg::TABLE_CAPACITY) begin
          ans.status = srlt_pkg::STATUS_FULL;
        end else begin
          lock_lo[fill] = it.range_begin;
          lock_hi[fill] = it.range_end;
          fill++;
        end
      end else begin
        for (k = 0; k < fill && !found; k++) begin
          if (it.sector >= lock_lo[k] && it.sector < lock_hi[k]) begin
            ans.remaining = lock_hi[k] - it.sector;
            found         = 1'b1;
          end
        end
      end
      owed.push_back(ans);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare_answer(logic [63:0] remaining, srlt_pkg::status_t status);
      answer_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result remaining=%0h status=%0d", remaining, status));
        return;
      end
      want = owed.pop_front();
      if (remaining !== want.remaining)
        report($sformatf("locked_remaining %0h, expected %0h", remaining, want.remaining));
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
    endtask
  endclass

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata  = '0;   // range_begin[63:0], range_end[127:64], sector[191:128]
  logic [0:0]   s_tuser  = '0;   // cmd[0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;         // locked_remaining[63:0]
  logic [0:0]   m_tuser;         // status[0]

  lock_tracker tracker = new();
  bit          idle_on       = 1'b1;
  bit          stall_request = 1'b0;

  sector_range_lock_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(srlt_pkg::item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.sector, it.range_end, it.range_begin};
    s_tuser  <= it.cmd;
    do @(posedge clk); while (!s_tready);
    tracker.note_request(it);
  endtask

  task automatic send_add(logic [63:0] b, logic [63:0] e);
    srlt_pkg::item_t it;
    it.cmd         = srlt_pkg::CMD_ADD;
    it.range_begin = b;
    it.range_end   = e;
    it.sector      = rand64();
    send_item(it);
  endtask

  task automatic send_check(logic [63:0] s);
    srlt_pkg::item_t it;
    it.cmd         = srlt_pkg::CMD_CHECK;
    it.range_begin = rand64();
    it.range_end   = rand64();
    it.sector      = s;
    send_item(it);
  endtask

  // A short range that overlaps nothing stored, so it is appended (or dropped when full).
  function automatic srlt_pkg::item_t fresh_add();
    srlt_pkg::item_t it;
    it.cmd    = srlt_pkg::CMD_ADD;
    it.sector = rand64();
    do begin
      it.range_begin = rand64();
      it.range_end   = it.range_begin + 64'($urandom_range(1, 16));
    end while (it.range_end < it.range_begin ||
               tracker.first_overlap(it.range_begin, it.range_end) >= 0);
    return it;
  endfunction

  task automatic send_random();
    srlt_pkg::item_t it;
    int              pick;
    int              idx;
    logic [63:0]     span;
    logic [63:0]     tmp;
    it.range_begin = rand64();
    it.range_end   = rand64();
    it.sector      = rand64();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.cmd = srlt_pkg::CMD_CHECK;
      pick   = $urandom_range(0, 9);
      if (pick < 6 && tracker.fill > 0) begin
        // Aim at the edges and the inside of a stored range.
        idx = $urandom_range(0, tracker.fill - 1);
        case ($urandom_range(0, 4))
          0: it.sector = tracker.lock_lo[idx];
          1: it.sector = tracker.lock_hi[idx] - 1;
          2: it.sector = tracker.lock_hi[idx];
          3: it.sector = tracker.lock_lo[idx] - 1;
          default: begin
            span = tracker.lock_hi[idx] - tracker.lock_lo[idx];
            if (tracker.lock_hi[idx] > tracker.lock_lo[idx])
              it.sector = tracker.lock_lo[idx] + rand64() % span;
          end
        endcase
      end else if (pick < 8) begin
        it.sector = 64'($urandom_range(0, 9000));
      end
    end else begin
      it.cmd = srlt_pkg::CMD_ADD;
      pick   = $urandom_range(0, 99);
      if (pick < 50) begin
        // Crowded low window, so adds often widen an earlier range.
        it.range_begin = 64'($urandom_range(0, 8191));
        if ($urandom_range(0, 19) == 0)
          it.range_end = it.range_begin >> 1;
        else
          it.range_end = it.range_begin + 64'($urandom_range(0, 255));
      end else if (pick < 85) begin
        it.range_end = it.range_begin + 64'($urandom_range(1, 1 << 20));
      end else if (it.range_begin < it.range_end) begin
        tmp            = it.range_begin;
        it.range_begin = it.range_end;
        it.range_end   = tmp;
      end
    end
    send_item(it);
  endtask

  initial begin : answer_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        tracker.compare_answer(m_tdata, srlt_pkg::status_t'(m_tuser));
      if (stall_request) begin
        stall_request = 1'b0;
        hold          = PRESSURE_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        hold     = $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[sector_range_lock_table] ERROR");
    $finish;
  end

  initial begin : stimulus
    srlt_pkg::item_t probe;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Touching, widening, empty and reversed ranges, and the ends of the sector space.
    send_check(64'd0);
    send_add(64'd10, 64'd20);
    send_check(64'd10);
    send_check(64'd19);
    send_check(64'd20);
    send_check(64'd9);
    send_add(64'd20, 64'd30);
    send_add(64'd5, 64'd12);
    send_add(64'd15, 64'd40);
    send_check(64'd25);
    send_add(64'd100, 64'd50);
    send_check(64'd75);
    send_add(64'd25, 64'd25);
    send_add(64'd300, 64'd300);
    send_check(64'd300);
    send_add(64'd0, 64'd1);
    send_check(64'd0);
    send_add(SECTOR_MAX - 16, SECTOR_MAX);
    send_check(SECTOR_MAX - 1);
    send_check(SECTOR_MAX);
    send_add(SECTOR_MAX, 64'd0);
    send_check(SECTOR_MAX - 16);
    send_add(SECTOR_MAX - 32, SECTOR_MAX - 8);
    send_check(SECTOR_MAX - 32);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) stall_request = 1'b1;
      send_random();
    end

    // The last items go at full rate on both sides.
    idle_on = 1'b0;
    if (tracker.fill > 0) send_check(tracker.lock_lo[tracker.fill - 1]);
    probe = fresh_add();
    send_item(probe);
    send_check(probe.range_begin);
    send_add(64'd0, SECTOR_MAX);
    send_add(SECTOR_MAX, SECTOR_MAX);
    send_check(SECTOR_MAX);
    repeat (10) send_random();
    s_tvalid <= 1'b0;

    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (srlt_pkg::TABLE_CAPACITY + 16) @(posedge clk);
    if (tracker.errors == 0)
      $display("[sector_range_lock_table] OK");
    else
      $display("[sector_range_lock_table] ERROR");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/srlt_pkg.sv
rtl/srlt_ram.sv
rtl/srlt_ctrl.sv
rtl/sector_range_lock_table.sv
sim/tb_top.sv
